// File: rtl/positional_insert_delete_list_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional insert/delete list
// Concurrent checks on the rising clock edge, off while reset is low.
// They are left empty when the code is synthesized.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PIDL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidl assertion failed");

`else

`define PIDL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/pidl_pkg.sv
// ---------------------------------------------------------------------------
// pidl_pkg
// Types and constants shared by the positional insert/delete list.
// ---------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int MAX_RESULTS = 32;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int LEN_OUT_W = 6;
    localparam int STATUS_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR   = 3'd0,
        K_APPEND  = 3'd1,
        K_INSERT  = 3'd2,
        K_DELETE  = 3'd3,
        K_DISPLAY = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DISP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // latch the input transaction
        logic exec;       // carry out the operation and load its result
        logic disp_step;  // emit the next displayed entry
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic disp_go;    // operation is a display of a non-empty list
        logic disp_last;  // the entry about to be displayed is the final one
    } t_sts;

endpackage

// File: rtl/pidl_ctrl.sv
// ---------------------------------------------------------------------------
// pidl_ctrl
// Sequencer: accept one transaction, execute it, then, for a display, walk its entries.
// ---------------------------------------------------------------------------
module pidl_ctrl
    import pidl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.disp_go ? S_DISP : S_IDLE;
                end
            end
            S_DISP: begin
                if (i_sts.out_free && i_sts.disp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall         = 1'b1;
        o_cmd           = '0;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            S_DISP: begin
                o_cmd.disp_step = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/pidl_dp.sv
// ---------------------------------------------------------------------------
// pidl_dp
// List cells with parallel shift, length register and output register.
// ---------------------------------------------------------------------------
module pidl_dp
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [VAL_W-1:0]     i_value,
    input  logic                        i_out_stall,
    output logic                        o_valid,
    output logic signed [VAL_W-1:0]     o_element,
    output logic [LEN_OUT_W-1:0]        o_length_now,
    output logic [STATUS_W-1:0]         o_status,
    output logic                        o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [KIND_W-1:0]          r_kind;
    logic [POS_W-1:0]           r_pos;
    logic signed [VAL_W-1:0]    r_value;
    logic signed [VAL_W-1:0]    r_store [DEPTH];
    logic [LW-1:0]              r_len;
    logic [IW-1:0]              r_idx;

    logic                       r_out_valid;
    logic signed [VAL_W-1:0]    r_element;
    logic [LEN_OUT_W-1:0]       r_length_now;
    t_status                    r_status;
    logic                       r_last;

    logic                       w_full;
    logic                       w_empty;
    logic [IW-1:0]              w_pos_ix;
    logic [IW-1:0]              w_rd_addr;
    logic signed [VAL_W-1:0]    w_rd_data;
    logic [LW-1:0]              w_idx_nx;
    logic                       w_disp_last;

    logic                       w_emit;
    logic                       w_do_ins;
    logic                       w_do_del;
    logic [IW-1:0]              w_wr_ix;
    t_status                    w_status;
    logic signed [VAL_W-1:0]    w_elem;
    logic [LW-1:0]              n_len;

    assign w_full    = (r_len == LW'(DEPTH));
    assign w_empty   = (r_len == '0);
    assign w_pos_ix  = IW'(r_pos);
    assign w_rd_addr = i_cmd.disp_step ? r_idx : w_pos_ix;
    assign w_rd_data = r_store[w_rd_addr];

    // display stops at the list end or at the result limit, whichever comes first
    assign w_idx_nx    = LW'(r_idx) + LW'(1);
    assign w_disp_last = (w_idx_nx == r_len) || (32'(w_idx_nx) == 32'(MAX_RESULTS));

    always_comb begin
        w_emit   = 1'b0;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        w_wr_ix  = w_pos_ix;
        w_status = ST_OK;
        w_elem   = '0;
        n_len    = r_len;
        case (r_kind) inside
            K_CLEAR: begin
                w_emit = 1'b1;
                n_len  = '0;
            end
            K_APPEND, K_INSERT: begin
                w_emit = 1'b1;
                if (w_full) begin
                    w_status = ST_FULL;
                end else if ((r_kind == K_INSERT) && (32'(r_pos) > 32'(r_len))) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_do_ins = 1'b1;
                    w_wr_ix  = (r_kind == K_APPEND) ? IW'(r_len) : w_pos_ix;
                    n_len    = r_len + LW'(1);
                end
            end
            K_DELETE: begin
                w_emit = 1'b1;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (32'(r_pos) >= 32'(r_len)) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_do_del = 1'b1;
                    w_elem   = w_rd_data;
                    n_len    = r_len - LW'(1);
                end
            end
            K_DISPLAY: begin
                if (w_empty) begin
                    w_emit   = 1'b1;
                    w_status = ST_EMPTY;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    // cells shift in parallel: up past an insert point, down from a delete point
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (w_do_ins) begin
                    if (IW'(j) == w_wr_ix) begin
                        r_store[j] <= r_value;
                    end else if (IW'(j) > w_wr_ix) begin
                        r_store[j] <= r_store[(j > 0) ? j - 1 : 0];
                    end
                end else if (w_do_del) begin
                    if (IW'(j) >= w_pos_ix) begin
                        r_store[j] <= r_store[(j < DEPTH - 1) ? j + 1 : j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.exec) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.disp_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && w_emit) || i_cmd.disp_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_emit) begin
            r_element    <= w_elem;
            r_length_now <= LEN_OUT_W'(n_len);
            r_status     <= w_status;
            r_last       <= 1'b1;
        end else if (i_cmd.disp_step) begin
            r_element    <= w_rd_data;
            r_length_now <= LEN_OUT_W'(r_len);
            r_status     <= ST_OK;
            r_last       <= w_disp_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.disp_go   = (r_kind == K_DISPLAY) && !w_empty;
    assign o_sts.disp_last = w_disp_last;

    assign o_valid      = r_out_valid;
    assign o_element    = r_element;
    assign o_length_now = r_length_now;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

// File: rtl/positional_insert_delete_list.sv
// ---------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words: clear, append, insert, delete, display.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_kind, i_position, i_value
//  result  | out       | o_valid / i_stall  | o_element, o_length_now, o_status,
//          |           |                    | o_last
//
//  Each transaction is accepted, then executed; a display then emits its entries in turn.
//  The list cells shift in parallel, so insert and delete finish in the execute cycle.
//  A result waiting in the output register lets the next transaction be accepted;
//  execution then waits for the output register to free.
//  Synchronous active-low reset clears the length; the cells are not cleared.
// ---------------------------------------------------------------------------
`include "positional_insert_delete_list_defines.svh"

module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [VAL_W-1:0]     i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VAL_W-1:0]     o_element,
    output logic [LEN_OUT_W-1:0]        o_length_now,
    output logic [STATUS_W-1:0]         o_status,
    output logic                        o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    pidl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pidl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .o_element    (o_element),
        .o_length_now (o_length_now),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    // never load a result over one that is still held
    `PIDL_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_cmd.exec || w_cmd.disp_step, !o_valid || !i_stall)
    // an accepted transaction holds off the next one
    `PIDL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a display still in progress keeps the input stalled
    `PIDL_ASSERT_IMPLY(a_disp_holds_input, i_clk, i_rst_n, o_valid && !o_last, o_stall)

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Runs the positional insert/delete list through directed and random
// operations. Both handshakes idle at random, and each result is compared
// field by field against a mirror of the list kept in the bench.
// ---------------------------------------------------------------------------
module tb;
    import pidl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_OPS  = 27;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int DRAIN_LIMIT = 200000;

    // kinds the block ignores
    localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

    typedef struct {
        logic signed [VAL_W-1:0] element;
        logic [LEN_OUT_W-1:0]    length_now;
        t_status                 status;
        logic                    last;
    } t_list_result;

    class list_mirror;
        logic signed [VAL_W-1:0] cells [LIST_DEPTH];
        int                      length;
        t_list_result            due_results [$];
        int                      bad_count;

        function new();
            length    = 0;
            bad_count = 0;
        endfunction

        function void note_bad(string msg);
            bad_count++;
            if (bad_count <= 10)
                $display("%s", msg);
        endfunction

        function void queue_result(logic signed [VAL_W-1:0] element, t_status status,
                                   logic last);
            t_list_result r;
            r.element    = element;
            r.length_now = LEN_OUT_W'(length);
            r.status     = status;
            r.last       = last;
            due_results.push_back(r);
        endfunction

        // Apply one accepted transaction to the mirror and queue its results.
        function void apply_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
            int j;
            int count;
            logic signed [VAL_W-1:0] removed;
            case (kind)
                K_CLEAR: begin
                    length = 0;
                    queue_result('0, ST_OK, 1'b1);
                end
                K_APPEND: begin
                    if (length >= LIST_DEPTH) begin
                        queue_result('0, ST_FULL, 1'b1);
                    end else begin
                        cells[length] = val;
                        length++;
                        queue_result('0, ST_OK, 1'b1);
                    end
                end
                K_INSERT: begin
                    if (length >= LIST_DEPTH) begin
                        queue_result('0, ST_FULL, 1'b1);
                    end else if (int'(pos) > length) begin
                        queue_result('0, ST_BADPOS, 1'b1);
                    end else begin
                        for (j = length; j > int'(pos); j--)
                            cells[j] = cells[j-1];
                        cells[pos] = val;
                        length++;
                        queue_result('0, ST_OK, 1'b1);
                    end
                end
                K_DELETE: begin
                    if (length == 0) begin
                        queue_result('0, ST_EMPTY, 1'b1);
                    end else if (int'(pos) >= length) begin
                        queue_result('0, ST_BADPOS, 1'b1);
                    end else begin
                        removed = cells[pos];
                        for (j = int'(pos); j + 1 < length; j++)
                            cells[j] = cells[j+1];
                        length--;
                        queue_result(removed, ST_OK, 1'b1);
                    end
                end
                K_DISPLAY: begin
                    count = (length > MAX_RESULTS) ? MAX_RESULTS : length;
                    if (count == 0)
                        queue_result('0, ST_EMPTY, 1'b1);
                    for (j = 0; j < count; j++)
                        queue_result(cells[j], ST_OK, j + 1 == count);
                end
                default: ;
            endcase
        endfunction

        function void match_result(logic signed [VAL_W-1:0] element,
                                   logic [LEN_OUT_W-1:0] length_now,
                                   logic [STATUS_W-1:0] status, logic last);
            t_list_result want;
            if (due_results.size() == 0) begin
                note_bad($sformatf("unexpected result: element %0d length %0d status %0d last %0d",
                                   element, length_now, status, last));
                return;
            end
            want = due_results.pop_front();
            if (element !== want.element || length_now !== want.length_now ||
                status !== want.status || last !== want.last)
                note_bad($sformatf({"result mismatch: want element %0d length %0d status %0d ",
                                    "last %0d, got element %0d length %0d status %0d last %0d"},
                                   want.element, want.length_now, want.status, want.last,
                                   element, length_now, status, last));
        endfunction

        function void close_out();
            if (due_results.size() != 0) begin
                $display("%0d results never arrived", due_results.size());
                bad_count += due_results.size();
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [KIND_W-1:0]       i_kind = K_CLEAR;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [VAL_W-1:0] o_element;
    logic [LEN_OUT_W-1:0]    o_length_now;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_last;

    list_mirror mirror = new();
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_request = 1'b0;

    positional_insert_delete_list uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_element    (o_element),
        .o_length_now (o_length_now),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("tb failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        return tx_steady ? 0 : idle_len();
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            mirror.match_result(o_element, o_length_now, o_status, o_last);
    end

    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.apply_op(kind, pos, val);
    endtask

    // Pick a mostly well-formed operation for the current list length.
    task automatic issue_random_op(input int gap, output bit counted);
        int pick;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 3)       kind = K_CLEAR;
        else if (pick < 28) kind = K_APPEND;
        else if (pick < 53) kind = K_INSERT;
        else if (pick < 88) kind = K_DELETE;
        else if (pick < 95) kind = K_DISPLAY;
        else begin
            kind    = KIND_W'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST));
            counted = 1'b0;
        end
        pos = POS_W'($urandom);
        if ($urandom_range(0, 99) < 85) begin
            if (kind == K_INSERT)
                pos = POS_W'($urandom_range(0, (mirror.length < 31) ? mirror.length : 31));
            else if (kind == K_DELETE && mirror.length > 0)
                pos = POS_W'($urandom_range(0, mirror.length - 1));
        end
        case ($urandom_range(0, 9))
            0: val = 32'sh7FFF_FFFF;
            1: val = 32'sh8000_0000;
            default: val = $urandom;
        endcase
        send_op(kind, pos, val, gap);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (mirror.due_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin : stimulus
        int done_ops;
        bit counted;
        logic [KIND_W-1:0] spare;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes of value and position, every kind
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_op(K_DISPLAY, 5'd0, 32'sd0, 0);
        send_op(K_DELETE, 5'd0, 32'sd0, 0);
        send_op(K_INSERT, 5'd1, 32'sd7, 0);
        send_op(K_INSERT, 5'd31, 32'sd7, 0);
        send_op(K_INSERT, 5'd0, 32'sh7FFF_FFFF, 0);
        send_op(K_APPEND, 5'd31, 32'sh8000_0000, 0);
        send_op(K_APPEND, 5'd0, -32'sd1, 0);
        send_op(K_INSERT, 5'd1, 32'sd0, 0);
        send_op(K_INSERT, 5'd4, 32'sd12345, 0);
        send_op(K_DISPLAY, 5'd0, 32'sd0, 0);
        send_op(K_DELETE, 5'd5, 32'sd0, 0);
        send_op(K_DELETE, 5'd31, 32'sd0, 0);
        send_op(K_DELETE, 5'd0, 32'sd0, 0);
        send_op(K_DELETE, 5'd3, 32'sd0, 0);
        for (spare = K_SPARE_FIRST; spare != K_CLEAR; spare++)
            send_op(spare, 5'd0, 32'sd99, 0);
        send_op(K_DISPLAY, 5'd0, 32'sd0, 0);
        send_op(K_CLEAR, 5'd0, 32'sd0, 0);
        send_op(K_DISPLAY, 5'd0, 32'sd0, 0);
        send_op(K_APPEND, 5'd0, 32'sh5A5A_A5A5, 0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // hold the result side off while offering back-to-back transactions
        hold_request = 1'b1;
        repeat (20) issue_random_op(0, counted);

        // fill to full, then work the full and one-below-full edges
        send_op(K_CLEAR, 5'd0, 32'sd0, next_gap());
        while (mirror.length < LIST_DEPTH)
            send_op(K_APPEND, POS_W'($urandom), $urandom, next_gap());
        send_op(K_APPEND, 5'd0, 32'sd1, next_gap());
        send_op(K_INSERT, 5'd0, 32'sd2, next_gap());
        send_op(K_INSERT, 5'd31, 32'sd3, next_gap());
        send_op(K_DISPLAY, 5'd0, 32'sd0, next_gap());
        send_op(K_DELETE, 5'd31, 32'sd0, next_gap());
        send_op(K_DELETE, 5'd31, 32'sd0, next_gap());
        send_op(K_INSERT, 5'd31, $urandom, next_gap());
        send_op(K_DELETE, 5'd0, 32'sd0, next_gap());
        send_op(K_DISPLAY, 5'd0, 32'sd0, next_gap());

        // pause the input side until every result is back
        i_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        done_ops = 0;
        while (done_ops < RANDOM_OPS) begin
            if (done_ops % 25 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            issue_random_op(next_gap(), counted);
            if (counted)
                done_ops++;
        end
        i_valid <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        mirror.close_out();
        if (mirror.bad_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
